### hw/rtl/deq_pkg.sv
// shared types and constants for the double-ended queue
package deq_pkg;

  localparam int DEPTH    = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int REQ_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_REAR  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_REAR   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_TAKE_LEFT,
    CELL_TAKE_RIGHT,
    CELL_LOAD,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
  } cell_word_t;

endpackage

### hw/rtl/deq_if.sv
// request and response channel interfaces of the double-ended queue
interface deq_req_if;
  logic                              valid;
  logic                              ready;
  logic [deq_pkg::REQ_W-1:0]         req_type;
  logic signed [deq_pkg::DATA_W-1:0] push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink (input valid, req_type, push_value, output ready);
endinterface

interface deq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [deq_pkg::DATA_W-1:0] popped_value;
  logic signed [deq_pkg::DATA_W-1:0] front_value;
  logic signed [deq_pkg::DATA_W-1:0] rear_value;
  logic [deq_pkg::COUNT_W-1:0]       item_count;
  logic [deq_pkg::STATUS_W-1:0]      status;

  modport source (output valid, popped_value, front_value, rear_value, item_count, status,
                  input ready);
  modport sink (input valid, popped_value, front_value, rear_value, item_count, status,
                output ready);
endinterface

### hw/rtl/double_ended_queue.sv
// double-ended queue built as a row of shifting cells
//
// req channel: one word per request, req_type selects push front, push rear,
// pop front or pop rear; push_value is used by pushes only.
// rsp channel: one word per request with the popped value, the front and
// rear values after the request (0 when empty), the element count and a
// status (ok, pop on empty ignored, push on full dropped).
// cell 0 always holds the front element, so pushes and pops at the front
// shift the whole row by one place at the same time; the rear is the last
// valid cell and is reached through one mux indexed by the count.
// the response is registered and appears in the cycle after the request is
// taken; while every response is taken, one request per cycle is sustained.
// the response is held in an output register: while the receiver stalls,
// it holds and the request side is held off; when the response is taken a
// new request is accepted in that same cycle.
// reset empties the queue at once (cell valid bits and the count clear) and
// drops any pending response; cell contents are not cleared.
module double_ended_queue (
  input  logic              clk,
  input  logic              rst,
  deq_req_if.sink           req,
  deq_rsp_if.source         rsp
);

  deq_pkg::cell_word_t cells [deq_pkg::DEPTH];
  deq_pkg::cell_op_t   ops   [deq_pkg::DEPTH];

  logic [deq_pkg::CNT_W-1:0]         count;
  logic [deq_pkg::CNT_W-1:0]         count_next;
  logic [deq_pkg::IDX_W-1:0]         rear_idx;
  logic signed [deq_pkg::DATA_W-1:0] rear_data;
  logic                              out_valid;
  logic signed [deq_pkg::DATA_W-1:0] popped;
  logic signed [deq_pkg::DATA_W-1:0] popped_next;
  deq_pkg::status_t                  status;
  deq_pkg::status_t                  status_next;
  deq_pkg::req_t                     kind;
  logic                              accept;
  logic                              empty;
  logic                              full;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign kind      = deq_pkg::req_t'(req.req_type);
  assign empty     = (count == '0);
  assign full      = (count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign rear_idx  = deq_pkg::IDX_W'(count - deq_pkg::CNT_W'(1));
  assign rear_data = cells[rear_idx].data;

  // per-cell command from the request and the cell's place in the row
  for (genvar i = 0; i < deq_pkg::DEPTH; i++) begin : g_cell
    deq_pkg::cell_word_t left;
    deq_pkg::cell_word_t right;

    if (i == 0) begin : g_first
      assign left = '{valid: 1'b1, data: req.push_value};
    end else begin : g_mid_l
      assign left = cells[i-1];
    end

    if (i == deq_pkg::DEPTH - 1) begin : g_last
      assign right = '{valid: 1'b0, data: '0};
    end else begin : g_mid_r
      assign right = cells[i+1];
    end

    always_comb begin
      ops[i] = deq_pkg::CELL_HOLD;
      if (accept) begin
        unique case (kind)
          deq_pkg::REQ_PUSH_FRONT: begin
            if (!full) ops[i] = deq_pkg::CELL_TAKE_LEFT;
          end
          deq_pkg::REQ_PUSH_REAR: begin
            if (!full && count == deq_pkg::CNT_W'(i)) ops[i] = deq_pkg::CELL_LOAD;
          end
          deq_pkg::REQ_POP_FRONT: begin
            if (!empty) ops[i] = deq_pkg::CELL_TAKE_RIGHT;
          end
          deq_pkg::REQ_POP_REAR: begin
            if (!empty && count == deq_pkg::CNT_W'(i + 1)) ops[i] = deq_pkg::CELL_CLEAR;
          end
        endcase
      end
    end

    deq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (ops[i]),
      .push_data (req.push_value),
      .left      (left),
      .right     (right),
      .word      (cells[i])
    );
  end

  always_comb begin
    count_next  = count;
    popped_next = '0;
    status_next = deq_pkg::ST_OK;
    unique case (kind)
      deq_pkg::REQ_PUSH_FRONT, deq_pkg::REQ_PUSH_REAR: begin
        if (full) status_next = deq_pkg::ST_FULL;
        else      count_next  = count + deq_pkg::CNT_W'(1);
      end
      deq_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          popped_next = cells[0].data;
          count_next  = count - deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::REQ_POP_REAR: begin
        if (empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          popped_next = rear_data;
          count_next  = count - deq_pkg::CNT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped <= popped_next;
      status <= status_next;
    end
  end

  // front and rear come straight from the row, which only moves on accept
  assign rsp.valid        = out_valid;
  assign rsp.popped_value = popped;
  assign rsp.front_value  = cells[0].valid ? cells[0].data : '0;
  assign rsp.rear_value   = empty ? '0 : rear_data;
  assign rsp.item_count   = deq_pkg::COUNT_W'(count);
  assign rsp.status       = status;

endmodule

### hw/rtl/deq_cell.sv
// one storage cell of the queue row, shifting with its neighbors
module deq_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  deq_pkg::cell_op_t                 op,
  input  logic signed [deq_pkg::DATA_W-1:0] push_data,
  input  deq_pkg::cell_word_t               left,
  input  deq_pkg::cell_word_t               right,
  output deq_pkg::cell_word_t               word
);

  logic                              valid;
  logic signed [deq_pkg::DATA_W-1:0] data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (op)
        deq_pkg::CELL_TAKE_LEFT:  valid <= left.valid;
        deq_pkg::CELL_TAKE_RIGHT: valid <= right.valid;
        deq_pkg::CELL_LOAD:       valid <= 1'b1;
        deq_pkg::CELL_CLEAR:      valid <= 1'b0;
        default:                  valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      deq_pkg::CELL_TAKE_LEFT:  data <= left.data;
      deq_pkg::CELL_TAKE_RIGHT: data <= right.data;
      deq_pkg::CELL_LOAD:       data <= push_data;
      default:                  data <= data;
    endcase
  end

  assign word = '{valid: valid, data: data};

endmodule

### hw/rtl/deq_checker.sv
// port-level checks for the double-ended queue, bound to the top level
module deq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic signed [deq_pkg::DATA_W-1:0] popped_value,
  input logic signed [deq_pkg::DATA_W-1:0] front_value,
  input logic signed [deq_pkg::DATA_W-1:0] rear_value,
  input logic [deq_pkg::COUNT_W-1:0]       item_count,
  input logic [deq_pkg::STATUS_W-1:0]      status
);

  // count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> item_count <= deq_pkg::COUNT_W'(deq_pkg::DEPTH))
    else $error("item count above capacity");

  // an ignored pop leaves an empty queue and pops nothing
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == deq_pkg::ST_EMPTY |-> item_count == '0 && popped_value == '0)
    else $error("empty pop reported with data or elements");

  // a dropped push only happens with the queue full
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == deq_pkg::ST_FULL
      |-> item_count == deq_pkg::COUNT_W'(deq_pkg::DEPTH) && popped_value == '0)
    else $error("full status with room left");

  // an empty queue shows zero ends
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && item_count == '0 |-> front_value == '0 && rear_value == '0)
    else $error("empty queue shows nonzero front or rear");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(popped_value) && $stable(front_value)
      && $stable(rear_value) && $stable(item_count) && $stable(status))
    else $error("response changed while stalled");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .popped_value (rsp.popped_value),
  .front_value  (rsp.front_value),
  .rear_value   (rsp.rear_value),
  .item_count   (rsp.item_count),
  .status       (rsp.status)
);
